>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/pvtc_pkg.sv
// ----------------------------------------------------------------------------
// pvtc_pkg
// Widths, register codes, reset values and helpers for the point view
// transform and clip pipeline.
// ----------------------------------------------------------------------------
package pvtc_pkg;

  // field widths
  localparam int COORD_W    = 32;
  localparam int COEF_W     = 18;
  localparam int NUM_COLS   = 3;
  localparam int NUM_ROWS   = 3;
  localparam int ROW_W      = COEF_W * NUM_COLS;
  localparam int DIST_W     = 31;
  localparam int BOUND_W    = 2 * COORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int FRAC_W     = 16;

  // datapath widths
  localparam int PROD_W    = COEF_W + COORD_W;      // one coefficient product
  localparam int SUM_W     = PROD_W + 1;            // three products, Q.32
  localparam int MAG_W     = SUM_W - 1;             // magnitude of a sum
  localparam int DZS_W     = SUM_W + 1;             // signed depth
  localparam int DZ_W      = MAG_W;                 // positive depth
  localparam int HALF_W    = MAG_W / 2;             // multiplier split
  localparam int PP_W      = (MAG_W - HALF_W) + DIST_W;
  localparam int NUM_W     = MAG_W + DIST_W;        // dividend
  localparam int Q_W       = 32;                    // quotient bits
  localparam int DIV_STEPS = Q_W;
  localparam int SAT_W     = MAG_W + 1 - FRAC_W;    // magnitude before saturation

  localparam logic [SAT_W-1:0] MIN_MAG  = SAT_W'(1) << (COORD_W - 1);
  localparam logic [SAT_W-1:0] MAX_POS  = MIN_MAG - SAT_W'(1);
  localparam logic [SAT_W-1:0] SAT_BIG  = SAT_W'(1) << Q_W;
  localparam logic [MAG_W:0]   ROUND_HALF = (MAG_W + 1)'(1) << (FRAC_W - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y = 3'd6;

  // identity matrix at reset
  localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(1) << FRAC_W;
  localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(1) << (FRAC_W + COEF_W);
  localparam logic [ROW_W-1:0] ROW_Z_RST = ROW_W'(1) << (FRAC_W + 2 * COEF_W);

  // per-item flags travelling with the data
  typedef struct packed {
    logic persp;
    logic zc;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } tag_t;

  // signed coefficient of one column
  function automatic logic signed [COEF_W-1:0] coef_of(input logic [ROW_W-1:0] row,
                                                      input logic [1:0] col);
    logic signed [COEF_W-1:0] c;
    c = $signed(row[col * COEF_W +: COEF_W]);
    return c;
  endfunction

  // sign and magnitude to saturated two's complement
  function automatic logic [COORD_W-1:0] sat_signed(input logic neg,
                                                   input logic [SAT_W-1:0] mag);
    logic [COORD_W-1:0] r;
    if (neg) begin
      if (mag >= MIN_MAG) r = {1'b1, {(COORD_W - 1){1'b0}}};
      else r = -mag[COORD_W-1:0];
    end else if (mag > MAX_POS) begin
      r = {1'b0, {(COORD_W - 1){1'b1}}};
    end else begin
      r = mag[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/point_view_transform_clip.sv
// ----------------------------------------------------------------------------
// point_view_transform_clip
// Rotates a Q16.16 point by the view matrix, applies perspective division
// and flags depth clipping and window visibility.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid/in_ready   | point_x, point_y, point_z
//  output   | out_valid/out_ready | view_x, view_y, visible, z_clipped
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  one point per cycle while the output is not stalled; the pipeline is the
//  32-step restoring divider pipeline plus seven arithmetic stages
//  a one-entry skid buffer takes a transfer while the output holds a result
//  the whole pipeline advances when the output register is empty or taken
//  synchronous reset clears valid bits and loads the register reset values
//
module point_view_transform_clip
  import pvtc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COORD_W-1:0]   point_x,
  input  logic signed [COORD_W-1:0]   point_y,
  input  logic signed [COORD_W-1:0]   point_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_W-1:0]   view_x,
  output logic signed [COORD_W-1:0]   view_y,
  output logic                        visible,
  output logic                        z_clipped,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

`include "assert_macros.svh"

  // configuration registers
  logic                 mode_3d;
  logic [ROW_W-1:0]     row [NUM_ROWS];
  logic [DIST_W-1:0]    view_distance;
  logic [BOUND_W-1:0]   clip_x_bounds;
  logic [BOUND_W-1:0]   clip_y_bounds;

  logic en;

  // skid buffer
  logic                      skid_valid;
  logic signed [COORD_W-1:0] skid_pt [NUM_COLS];
  logic signed [COORD_W-1:0] feed_pt [NUM_COLS];
  logic                      feed_valid;

  // stage 1: products
  logic                      s1_valid;
  logic signed [PROD_W-1:0]  s1_prod [NUM_ROWS][NUM_COLS];
  logic signed [COORD_W-1:0] s1_px, s1_py;

  // stage 2: dot products
  logic                      s2_valid;
  logic signed [SUM_W-1:0]   s2_sum [NUM_ROWS];
  logic signed [COORD_W-1:0] s2_px, s2_py;

  // stage 3: depth and magnitudes
  logic signed [DZS_W-1:0]   dz_s;
  logic                      persp_now;
  logic                      s3_valid;
  tag_t                      s3_tag;
  logic [DZ_W-1:0]           s3_dz;
  logic [MAG_W-1:0]          s3_mag_x, s3_mag_y;
  logic signed [COORD_W-1:0] s3_px, s3_py;

  // stage 4: partial products and parallel rounding
  logic [MAG_W:0]            rsum_x, rsum_y;
  logic                      s4_valid;
  tag_t                      s4_tag;
  logic [DZ_W-1:0]           s4_dz;
  logic [PP_W-1:0]           s4_plx, s4_phx, s4_ply, s4_phy;
  logic [COORD_W-1:0]        s4_ex, s4_ey;

  // divider pipeline, entry 0 is the dividend stage
  logic [NUM_W-1:0]          n_x, n_y;
  logic                      dv_valid [DIV_STEPS+1];
  tag_t                      dv_tag   [DIV_STEPS+1];
  logic [DZ_W-1:0]           dv_dz    [DIV_STEPS+1];
  logic [DZ_W-1:0]           dv_rem_x [DIV_STEPS+1];
  logic [DZ_W-1:0]           dv_rem_y [DIV_STEPS+1];
  logic [Q_W-1:0]            dv_nq_x  [DIV_STEPS+1];
  logic [Q_W-1:0]            dv_nq_y  [DIV_STEPS+1];
  logic [COORD_W-1:0]        dv_ex    [DIV_STEPS+1];
  logic [COORD_W-1:0]        dv_ey    [DIV_STEPS+1];

  // result stage
  logic                      inc_x, inc_y;
  logic [Q_W:0]              q_x, q_y;
  logic [COORD_W-1:0]        pv_x, pv_y;
  logic                      r1_valid;
  logic                      r1_zc;
  logic signed [COORD_W-1:0] r1_x, r1_y;

  // pipeline advances when the output register is free
  assign en        = !out_valid || out_ready;
  assign in_ready  = !skid_valid;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_3d       <= 1'b0;
      row[0]        <= ROW_X_RST;
      row[1]        <= ROW_Y_RST;
      row[2]        <= ROW_Z_RST;
      view_distance <= '0;
      clip_x_bounds <= '0;
      clip_y_bounds <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:   mode_3d       <= cfg_data[0];
        REG_ROW_X:  row[0]        <= cfg_data[ROW_W-1:0];
        REG_ROW_Y:  row[1]        <= cfg_data[ROW_W-1:0];
        REG_ROW_Z:  row[2]        <= cfg_data[ROW_W-1:0];
        REG_DIST:   view_distance <= cfg_data[DIST_W-1:0];
        REG_CLIP_X: clip_x_bounds <= cfg_data;
        REG_CLIP_Y: clip_y_bounds <= cfg_data;
        default: ;
      endcase
    end
  end

  // skid buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_valid && in_ready) begin
      skid_pt[0] <= point_x;
      skid_pt[1] <= point_y;
      skid_pt[2] <= point_z;
    end
  end

  // pick the waiting item first
  always_comb begin
    feed_valid = skid_valid || in_valid;
    if (skid_valid) begin
      feed_pt[0] = skid_pt[0];
      feed_pt[1] = skid_pt[1];
      feed_pt[2] = skid_pt[2];
    end else begin
      feed_pt[0] = point_x;
      feed_pt[1] = point_y;
      feed_pt[2] = point_z;
    end
  end

  // valid chain of the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      s4_valid    <= 1'b0;
      dv_valid[0] <= 1'b0;
      r1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else if (en) begin
      s1_valid    <= feed_valid;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      s4_valid    <= s3_valid;
      dv_valid[0] <= s4_valid;
      r1_valid    <= dv_valid[DIV_STEPS];
      out_valid   <= r1_valid;
    end
  end

  // stage 1: coefficient products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          s1_prod[r][c] <= coef_of(row[r], 2'(c)) * feed_pt[c];
        end
      end
      s1_px <= feed_pt[0];
      s1_py <= feed_pt[1];
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        s2_sum[r] <= SUM_W'(s1_prod[r][0]) + SUM_W'(s1_prod[r][1]) + SUM_W'(s1_prod[r][2]);
      end
      s2_px <= s1_px;
      s2_py <= s1_py;
    end
  end

  // stage 3: depth, clip test and magnitudes
  assign persp_now = mode_3d && (view_distance != '0);
  assign dz_s = DZS_W'($signed({1'b0, view_distance, FRAC_W'(0)})) - DZS_W'(s2_sum[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tag.persp <= persp_now;
      s3_tag.zc    <= persp_now && (dz_s[DZS_W-1] || dz_s == '0);
      s3_tag.neg_x <= s2_sum[0][SUM_W-1];
      s3_tag.neg_y <= s2_sum[1][SUM_W-1];
      s3_tag.ovf_x <= 1'b0;
      s3_tag.ovf_y <= 1'b0;
      s3_dz        <= dz_s[DZ_W-1:0];
      s3_mag_x     <= s2_sum[0][SUM_W-1] ? MAG_W'(-s2_sum[0]) : MAG_W'(s2_sum[0]);
      s3_mag_y     <= s2_sum[1][SUM_W-1] ? MAG_W'(-s2_sum[1]) : MAG_W'(s2_sum[1]);
      s3_px        <= s2_px;
      s3_py        <= s2_py;
    end
  end

  // stage 4: split multiply by the distance, parallel rounding
  assign rsum_x = {1'b0, s3_mag_x} + ROUND_HALF;
  assign rsum_y = {1'b0, s3_mag_y} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tag <= s3_tag;
      s4_dz  <= s3_dz;
      s4_plx <= PP_W'(s3_mag_x[HALF_W-1:0]) * PP_W'(view_distance);
      s4_phx <= PP_W'(s3_mag_x[MAG_W-1:HALF_W]) * PP_W'(view_distance);
      s4_ply <= PP_W'(s3_mag_y[HALF_W-1:0]) * PP_W'(view_distance);
      s4_phy <= PP_W'(s3_mag_y[MAG_W-1:HALF_W]) * PP_W'(view_distance);
      s4_ex  <= mode_3d ? sat_signed(s3_tag.neg_x, rsum_x[MAG_W:FRAC_W]) : s3_px;
      s4_ey  <= mode_3d ? sat_signed(s3_tag.neg_y, rsum_y[MAG_W:FRAC_W]) : s3_py;
    end
  end

  // dividend assembly and quotient overflow test
  assign n_x = NUM_W'(s4_plx) + (NUM_W'(s4_phx) << HALF_W);
  assign n_y = NUM_W'(s4_ply) + (NUM_W'(s4_phy) << HALF_W);

  always_ff @(posedge clk) begin
    if (en) begin
      dv_tag[0].persp <= s4_tag.persp;
      dv_tag[0].zc    <= s4_tag.zc;
      dv_tag[0].neg_x <= s4_tag.neg_x;
      dv_tag[0].neg_y <= s4_tag.neg_y;
      dv_tag[0].ovf_x <= DZ_W'(n_x[NUM_W-1:Q_W]) >= s4_dz;
      dv_tag[0].ovf_y <= DZ_W'(n_y[NUM_W-1:Q_W]) >= s4_dz;
      dv_dz[0]        <= s4_dz;
      dv_rem_x[0]     <= DZ_W'(n_x[NUM_W-1:Q_W]);
      dv_rem_y[0]     <= DZ_W'(n_y[NUM_W-1:Q_W]);
      dv_nq_x[0]      <= n_x[Q_W-1:0];
      dv_nq_y[0]      <= n_y[Q_W-1:0];
      dv_ex[0]        <= s4_ex;
      dv_ey[0]        <= s4_ey;
    end
  end

  // restoring divider, one quotient bit per stage for both axes
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DZ_W:0] tx, ty;
    logic          gex, gey;

    assign tx  = {dv_rem_x[k], dv_nq_x[k][Q_W-1]};
    assign ty  = {dv_rem_y[k], dv_nq_y[k][Q_W-1]};
    assign gex = tx >= {1'b0, dv_dz[k]};
    assign gey = ty >= {1'b0, dv_dz[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (en) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_tag[k+1]   <= dv_tag[k];
        dv_dz[k+1]    <= dv_dz[k];
        dv_rem_x[k+1] <= gex ? DZ_W'(tx - {1'b0, dv_dz[k]}) : tx[DZ_W-1:0];
        dv_rem_y[k+1] <= gey ? DZ_W'(ty - {1'b0, dv_dz[k]}) : ty[DZ_W-1:0];
        dv_nq_x[k+1]  <= {dv_nq_x[k][Q_W-2:0], gex};
        dv_nq_y[k+1]  <= {dv_nq_y[k][Q_W-2:0], gey};
        dv_ex[k+1]    <= dv_ex[k];
        dv_ey[k+1]    <= dv_ey[k];
      end
    end
  end

  // round half away from zero, saturate, pick the mode
  assign inc_x = {dv_rem_x[DIV_STEPS], 1'b0} >= {1'b0, dv_dz[DIV_STEPS]};
  assign inc_y = {dv_rem_y[DIV_STEPS], 1'b0} >= {1'b0, dv_dz[DIV_STEPS]};
  assign q_x   = {1'b0, dv_nq_x[DIV_STEPS]} + (Q_W + 1)'(inc_x);
  assign q_y   = {1'b0, dv_nq_y[DIV_STEPS]} + (Q_W + 1)'(inc_y);
  assign pv_x  = sat_signed(dv_tag[DIV_STEPS].neg_x,
                            dv_tag[DIV_STEPS].ovf_x ? SAT_BIG : SAT_W'(q_x));
  assign pv_y  = sat_signed(dv_tag[DIV_STEPS].neg_y,
                            dv_tag[DIV_STEPS].ovf_y ? SAT_BIG : SAT_W'(q_y));

  always_ff @(posedge clk) begin
    if (en) begin
      r1_zc <= dv_tag[DIV_STEPS].zc;
      priority if (dv_tag[DIV_STEPS].zc) begin
        r1_x <= '0;
        r1_y <= '0;
      end else if (dv_tag[DIV_STEPS].persp) begin
        r1_x <= pv_x;
        r1_y <= pv_y;
      end else begin
        r1_x <= dv_ex[DIV_STEPS];
        r1_y <= dv_ey[DIV_STEPS];
      end
    end
  end

  // output register with window test
  always_ff @(posedge clk) begin
    if (en) begin
      view_x    <= r1_x;
      view_y    <= r1_y;
      z_clipped <= r1_zc;
      visible   <= !r1_zc
                   && (r1_x > $signed(clip_x_bounds[COORD_W-1:0]))
                   && (r1_x < $signed(clip_x_bounds[BOUND_W-1:COORD_W]))
                   && (r1_y > $signed(clip_y_bounds[COORD_W-1:0]))
                   && (r1_y < $signed(clip_y_bounds[BOUND_W-1:COORD_W]));
    end
  end

  // checks
  `ASSERT_IMPL(a_clip_zero, clk, rst, out_valid && z_clipped, view_x == '0 && view_y == '0 && !visible, "clipped point not zeroed")
  `ASSERT_IMPL(a_skid_stall, clk, rst, skid_valid, out_valid, "skid holds an item while output empty")
  `ASSERT_NEXT(a_skid_drain, clk, rst, skid_valid && out_ready, !skid_valid, "skid not drained on advance")

endmodule

>>> tb/sv/point_view_transform_clip_checker.sv
// ----------------------------------------------------------------------------
// point_view_transform_clip_checker
// Watches the point, result and register channels, works out the expected
// view coordinates and flags of every point and compares each result in order.
// ----------------------------------------------------------------------------
module point_view_transform_clip_checker
  import pvtc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [COORD_W-1:0] view_x,
  input  logic signed [COORD_W-1:0] view_y,
  input  logic                      visible,
  input  logic                      z_clipped,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        pending
);

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               vis;
    logic               zc;
  } view_t;

  // shadow copy of the registers
  logic        m_mode;
  logic [53:0] m_row [3];
  logic [30:0] m_dist;
  logic [63:0] m_clipx, m_clipy;

  view_t expected_views[$];

  function automatic logic signed [63:0] row_dot(input logic [53:0] row,
                                                 input logic signed [63:0] px,
                                                 input logic signed [63:0] py,
                                                 input logic signed [63:0] pz);
    logic signed [63:0] c0, c1, c2;
    c0 = $signed(row[17:0]);
    c1 = $signed(row[35:18]);
    c2 = $signed(row[53:36]);
    return c0 * px + c1 * py + c2 * pz;
  endfunction

  function automatic logic signed [31:0] clamp(input logic neg, input logic [127:0] mag);
    if (neg) begin
      if (mag >= 128'h8000_0000) return 32'sh8000_0000;
      return -$signed(mag[31:0]);
    end
    if (mag > 128'h7fff_ffff) return 32'sh7fff_ffff;
    return mag[31:0];
  endfunction

  // Q.32 sum rounded to Q16.16, halves away from zero
  function automatic logic signed [31:0] round_sum(input logic signed [63:0] s);
    logic [127:0] mag;
    mag = s < 0 ? 128'(-s) : 128'(s);
    return clamp(s < 0, (mag + 128'h8000) >> 16);
  endfunction

  // s*d/dz rounded to nearest, halves away from zero
  function automatic logic signed [31:0] project(input logic signed [63:0] s,
                                                 input logic [30:0] d,
                                                 input logic [63:0] dz);
    logic [127:0] mag, num, q, r;
    mag = s < 0 ? 128'(-s) : 128'(s);
    num = mag * 128'(d);
    q = num / 128'(dz);
    r = num % 128'(dz);
    if (r >= 128'(dz) - r) q = q + 1;
    return clamp(s < 0, q);
  endfunction

  function automatic view_t transform(input logic signed [31:0] px,
                                      input logic signed [31:0] py,
                                      input logic signed [31:0] pz);
    view_t v;
    logic signed [63:0] sx, sy, sz, dz;
    v.zc = 1'b0;
    if (m_mode) begin
      sx = row_dot(m_row[0], px, py, pz);
      sy = row_dot(m_row[1], px, py, pz);
      if (m_dist != 0) begin
        sz = row_dot(m_row[2], px, py, pz);
        dz = ($signed({33'd0, m_dist}) <<< 16) - sz;
        if (dz <= 0) begin
          v.zc = 1'b1;
          v.vx = 0;
          v.vy = 0;
        end else begin
          v.vx = project(sx, m_dist, dz);
          v.vy = project(sy, m_dist, dz);
        end
      end else begin
        v.vx = round_sum(sx);
        v.vy = round_sum(sy);
      end
    end else begin
      v.vx = px;
      v.vy = py;
    end
    v.vis = !v.zc && v.vx > $signed(m_clipx[31:0]) && v.vx < $signed(m_clipx[63:32])
            && v.vy > $signed(m_clipy[31:0]) && v.vy < $signed(m_clipy[63:32]);
    return v;
  endfunction

  // track register writes, point transfers and result transfers
  always @(posedge clk) begin
    view_t e;
    int    errs;
    errs = 0;
    if (rst) begin
      m_mode <= 1'b0;
      m_row[0] <= ROW_X_RST;
      m_row[1] <= ROW_Y_RST;
      m_row[2] <= ROW_Z_RST;
      m_dist <= '0;
      m_clipx <= '0;
      m_clipy <= '0;
      fail_count <= 0;
      pending <= 0;
      expected_views.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   m_mode <= cfg_data[0];
          REG_ROW_X:  m_row[0] <= cfg_data[53:0];
          REG_ROW_Y:  m_row[1] <= cfg_data[53:0];
          REG_ROW_Z:  m_row[2] <= cfg_data[53:0];
          REG_DIST:   m_dist <= cfg_data[30:0];
          REG_CLIP_X: m_clipx <= cfg_data;
          REG_CLIP_Y: m_clipy <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_views.push_back(transform(point_x, point_y, point_z));
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          $error("unexpected result transfer");
          errs++;
        end else begin
          e = expected_views.pop_front();
          if (view_x !== e.vx) begin
            $error("view_x expected %0d actual %0d", e.vx, view_x);
            errs++;
          end
          if (view_y !== e.vy) begin
            $error("view_y expected %0d actual %0d", e.vy, view_y);
            errs++;
          end
          if (visible !== e.vis) begin
            $error("visible expected %0d actual %0d", e.vis, visible);
            errs++;
          end
          if (z_clipped !== e.zc) begin
            $error("z_clipped expected %0d actual %0d", e.zc, z_clipped);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= expected_views.size();
    end
  end

endmodule

>>> tb/sv/point_view_transform_clip_tb.sv
// ----------------------------------------------------------------------------
// point_view_transform_clip_tb
// Drives directed and random points through several register settings with
// random gaps and output stalls; a checker module compares every result.
// ----------------------------------------------------------------------------
module point_view_transform_clip_tb;
  import pvtc_pkg::*;

  localparam int LIMIT = 400000;

  logic                      clk, rst;
  logic                      in_valid, in_ready;
  logic signed [COORD_W-1:0] point_x, point_y, point_z;
  logic                      out_valid, out_ready;
  logic signed [COORD_W-1:0] view_x, view_y;
  logic                      visible, z_clipped;
  logic                      cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  int                        fail_count, pending;
  int                        cycles;
  logic                      sink_busy;

  point_view_transform_clip u_dut (.*);

  point_view_transform_clip_checker u_checker (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // output stalls, with quiet stretches
  initial begin
    int n;
    out_ready = 1'b0;
    sink_busy = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(199) == 0) sink_busy = ~sink_busy;
      if (!sink_busy) out_ready <= 1'b1;
      else begin
        n = gap_len();
        if (n == 0) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input bit use_gaps);
    int n;
    n = use_gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(400 << 16)) - (200 << 16));
    endcase
  endfunction

  function automatic logic [17:0] rand_coef();
    case ($urandom_range(4))
      0: return 18'($urandom());
      1: return $urandom_range(1) ? 18'h1ffff : 18'h20000;
      default: return 18'($signed($urandom_range(1 << 17)) - (1 << 16));
    endcase
  endfunction

  function automatic logic [63:0] rand_window();
    logic signed [31:0] lo, hi;
    lo = -$signed(32'($urandom_range(300 << 16)));
    hi = $signed(32'($urandom_range(300 << 16)));
    if ($urandom_range(7) == 0) return {lo, hi};
    return {hi, lo};
  endfunction

  // stimulus
  initial begin
    logic [31:0] extremes [6];
    extremes = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h1_0000, 32'hffff_0000};
    rst = 1'b1;
    in_valid = 1'b0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: pass-through extremes with reset registers
    foreach (extremes[i]) send_point(extremes[i], extremes[5 - i], extremes[i], 1'b0);
    drain();
    // window set, index beyond list ignored
    write_reg(REG_CLIP_X, {32'sh0010_0000, -32'sh0010_0000});
    write_reg(REG_CLIP_Y, {32'sh0010_0000, -32'sh0010_0000});
    write_reg(3'd7, 64'hffff_ffff_ffff_ffff);
    send_point(32'h0001_0000, 32'h0001_0000, 0, 1'b0);
    send_point(32'h0010_0000, 32'h0, 0, 1'b0);
    send_point(-32'sh000f_ffff, 32'h000f_ffff, 0, 1'b0);
    drain();
    // parallel 3d with extreme coefficients, bits above width set
    write_reg(REG_MODE, 64'hffff_ffff_ffff_fffe | 64'h1);
    write_reg(REG_ROW_X, {10'h3ff, 18'h20000, 18'h20000, 18'h20000});
    write_reg(REG_ROW_Y, {10'h3ff, 18'h1ffff, 18'h1ffff, 18'h1ffff});
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h0000_8000, 32'h0, 32'h0, 1'b0);
    drain();
    // perspective: depth at eye, behind eye, in front
    write_reg(REG_ROW_X, 64'(ROW_X_RST));
    write_reg(REG_ROW_Y, 64'(ROW_Y_RST));
    write_reg(REG_DIST, 64'hffff_ffff_0000_0000 | 64'h0005_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0005_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0006_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0004_ffff, 1'b0);
    send_point(32'h0000_0003, 32'hffff_fffd, 32'h8000_0000, 1'b0);
    drain();
    write_reg(REG_DIST, 64'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h1234_5678, 32'h8765_4321, 32'h8000_0000, 1'b0);
    drain();

    // random phases
    for (int phase = 0; phase < 18; phase++) begin
      write_reg(REG_MODE, (phase % 6 != 0) ? 64'h1 : 64'h0);
      write_reg(REG_ROW_X, {10'($urandom()), rand_coef(), rand_coef(), rand_coef()});
      write_reg(REG_ROW_Y, 64'({rand_coef(), rand_coef(), rand_coef()}));
      write_reg(REG_ROW_Z, 64'({rand_coef(), rand_coef(), rand_coef()}));
      case (phase % 3)
        0: write_reg(REG_DIST, 64'h0);
        1: write_reg(REG_DIST, 64'($urandom_range(1000 << 16, 1)));
        default: write_reg(REG_DIST, {$urandom(), $urandom()});
      endcase
      write_reg(REG_CLIP_X, phase == 5 ? {$urandom(), $urandom()} : rand_window());
      write_reg(REG_CLIP_Y, rand_window());
      for (int i = 0; i < 75; i++) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
      drain();
    end

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/pvtc_pkg.sv
design/point_view_transform_clip.sv
tb/sv/point_view_transform_clip_checker.sv
tb/sv/point_view_transform_clip_tb.sv
